FILE: design/tsf_pkg.sv
// shared types and constants of the touch sample filter
`timescale 1ns / 1ps

package tsf_pkg;

	localparam int SAMPLES_PER_GROUP_DEF = 40;
	localparam int ADC_BITS_DEF          = 12;

	localparam int SAMPLE_W    = 12;
	localparam int CMD_W       = 2;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 72;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int POS_W       = 16;
	localparam int GAIN_W      = 16;
	localparam int LIMIT_W     = 12;
	localparam int CAL_SHIFT   = 14;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PEN_UP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_RAW_MODE    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_X_GAIN      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_Y_GAIN      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_X_OFFSET    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_Y_OFFSET    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_AGREE_LIMIT = 3'd5;

	localparam logic [1:0] GRP_X0 = 2'd0;
	localparam logic [1:0] GRP_Y0 = 2'd1;
	localparam logic [1:0] GRP_X1 = 2'd2;
	localparam logic [1:0] GRP_Y1 = 2'd3;

	localparam logic [LIMIT_W-1:0] AGREE_LIMIT_RST = 12'd50;
	localparam logic [POS_W-1:0]   NO_TOUCH        = 16'hffff;

	typedef enum logic [1:0] {
		KIND_GROUP,
		KIND_PEN_UP,
		KIND_CLEAR
	} kind_t;

	typedef struct packed {
		logic             pair_agreed;
		logic             caught;
		logic             pressed;
		logic [POS_W-1:0] press_y;
		logic [POS_W-1:0] press_x;
		logic [POS_W-1:0] pos_y;
		logic [POS_W-1:0] pos_x;
	} result_t;

endpackage

FILE: design/touch_sample_filter_top.sv
// touch sample filter: trimmed-mean groups, pair agreement, calibration, pen state
// a result is registered through stages 1 to 5 and written into the output fifo before it shows on m_axis
// throughput: one input transaction per cycle; the pipeline never stalls and
// results queue in an 8-entry output fifo, tready drops only when fifo plus stages are full
// a result waiting on m_axis does not block input until that fifo budget is used up
// reset: asynchronous, all control and pen state cleared, agree_limit returns to 50
`timescale 1ns / 1ps

module touch_sample_filter_top #(
	parameter int SAMPLES_PER_GROUP = tsf_pkg::SAMPLES_PER_GROUP_DEF,
	parameter int ADC_BITS          = tsf_pkg::ADC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [tsf_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // sample[11:0], zero pad
	input  logic [tsf_pkg::CMD_W-1:0]        s_axis_tuser,  // cmd[1:0]
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// pos_x[15:0], pos_y[31:16], press_x[47:32], press_y[63:48],
	// pressed[64], caught[65], pair_agreed[66], zero pad
	output logic [tsf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tsf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tsf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tsf_pkg::*;

	localparam int CNT_W   = $clog2(SAMPLES_PER_GROUP);
	localparam int SUM_W   = ADC_BITS + $clog2(SAMPLES_PER_GROUP);
	localparam int DIV     = SAMPLES_PER_GROUP - 2;
	localparam int DIV_SH  = SUM_W + $clog2(DIV);
	localparam int RECIP_W = SUM_W + 1;
	localparam longint RECIP_L = ((longint'(1) << DIV_SH) + longint'(DIV) - 1) / longint'(DIV);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_GROUP - 1);
	localparam logic [ADC_BITS-1:0] ADC_MAX = '1;
	localparam int AVG_W   = ADC_BITS + 1;
	localparam int CMP_W   = ((ADC_BITS > LIMIT_W) ? ADC_BITS : LIMIT_W);
	localparam int MUL_W   = AVG_W + GAIN_W;
	localparam int OFF_W   = GAIN_W + CAL_SHIFT;
	localparam int T_W     = ((MUL_W > OFF_W) ? MUL_W : OFF_W) + 1;
	localparam int Q_W     = T_W - CAL_SHIFT;

	// configuration registers
	logic                     raw_mode_q;
	logic signed [GAIN_W-1:0] x_gain_q, y_gain_q, x_off_q, y_off_q;
	logic [LIMIT_W-1:0]       agree_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q    <= 1'b0;
			x_gain_q      <= '0;
			y_gain_q      <= '0;
			x_off_q       <= '0;
			y_off_q       <= '0;
			agree_limit_q <= AGREE_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RAW_MODE:    raw_mode_q    <= cfg_data[0];
				REG_X_GAIN:      x_gain_q      <= cfg_data;
				REG_Y_GAIN:      y_gain_q      <= cfg_data;
				REG_X_OFFSET:    x_off_q       <= cfg_data;
				REG_Y_OFFSET:    y_off_q       <= cfg_data;
				REG_AGREE_LIMIT: agree_limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// input side and group accumulation
	logic                 in_fire;
	logic [CMD_W-1:0]     cmd;
	logic [ADC_BITS-1:0]  smp;
	logic [CNT_W-1:0]     grp_cnt_q;
	logic [1:0]           grp_idx_q;
	logic [SUM_W-1:0]     grp_sum_q, acc_sum;
	logic [ADC_BITS-1:0]  grp_min_q, grp_max_q, acc_min, acc_max;
	logic                 grp_end;
	kind_t                in_kind;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign cmd     = s_axis_tuser;
	assign smp     = ADC_BITS'(s_axis_tdata[SAMPLE_W-1:0]);
	assign acc_sum = grp_sum_q + SUM_W'(smp);
	assign acc_min = (smp < grp_min_q) ? smp : grp_min_q;
	assign acc_max = (smp > grp_max_q) ? smp : grp_max_q;
	assign grp_end = (cmd == CMD_SAMPLE) && (grp_cnt_q == LAST_CNT);

	always_comb begin
		case (cmd)
			CMD_PEN_UP: in_kind = KIND_PEN_UP;
			CMD_CLEAR:  in_kind = KIND_CLEAR;
			default:    in_kind = KIND_GROUP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_cnt_q <= '0;
			grp_idx_q <= GRP_X0;
			grp_sum_q <= '0;
			grp_min_q <= ADC_MAX;
			grp_max_q <= '0;
		end else if (in_fire) begin
			case (cmd)
				CMD_SAMPLE: begin
					if (grp_end) begin
						grp_cnt_q <= '0;
						grp_idx_q <= grp_idx_q + 2'd1;
						grp_sum_q <= '0;
						grp_min_q <= ADC_MAX;
						grp_max_q <= '0;
					end else begin
						grp_cnt_q <= grp_cnt_q + CNT_W'(1);
						grp_sum_q <= acc_sum;
						grp_min_q <= acc_min;
						grp_max_q <= acc_max;
					end
				end
				CMD_PEN_UP: begin
					grp_cnt_q <= '0;
					grp_idx_q <= GRP_X0;
					grp_sum_q <= '0;
					grp_min_q <= ADC_MAX;
					grp_max_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// pipeline valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// stage 1: finished group or command
	kind_t               kind_s1;
	logic [1:0]          gidx_s1;
	logic [SUM_W-1:0]    sum_s1;
	logic [ADC_BITS-1:0] min_s1, max_s1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1 <= in_kind;
			gidx_s1 <= grp_idx_q;
			sum_s1  <= acc_sum;
			min_s1  <= acc_min;
			max_s1  <= acc_max;
		end
	end

	// stage 2: trimmed sum
	kind_t            kind_s2;
	logic [1:0]       gidx_s2;
	logic [SUM_W-1:0] trim_s2;

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		gidx_s2 <= gidx_s1;
		trim_s2 <= sum_s1 - SUM_W'(min_s1) - SUM_W'(max_s1);
	end

	// stage 3: reciprocal product, mean is its upper bits
	kind_t               kind_s3;
	logic [1:0]          gidx_s3;
	logic [PROD_W-1:0]   prod_s3;
	logic [ADC_BITS-1:0] mean_s3;

	always_ff @(posedge clk) begin
		kind_s3 <= kind_s2;
		gidx_s3 <= gidx_s2;
		prod_s3 <= PROD_W'(trim_s2) * PROD_W'(RECIP);
	end

	assign mean_s3 = ADC_BITS'(prod_s3 >> DIV_SH);

	logic [ADC_BITS-1:0] fmx_q, fmy_q, smx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmx_q <= '0;
			fmy_q <= '0;
			smx_q <= '0;
		end else if (v_s3 && (kind_s3 == KIND_GROUP)) begin
			case (gidx_s3)
				GRP_X0:  fmx_q <= mean_s3;
				GRP_Y0:  fmy_q <= mean_s3;
				GRP_X1:  smx_q <= mean_s3;
				default: ;
			endcase
		end
	end

	// agreement check and pair averages
	logic [ADC_BITS-1:0] dx, dy, ax, ay;
	logic [AVG_W-1:0]    sum_ax, sum_ay;
	logic                agree_x, agree_y;

	assign dx      = (fmx_q > smx_q) ? (fmx_q - smx_q) : (smx_q - fmx_q);
	assign dy      = (fmy_q > mean_s3) ? (fmy_q - mean_s3) : (mean_s3 - fmy_q);
	assign agree_x = CMP_W'(dx) < CMP_W'(agree_limit_q);
	assign agree_y = CMP_W'(dy) < CMP_W'(agree_limit_q);
	assign sum_ax  = AVG_W'(fmx_q) + AVG_W'(smx_q);
	assign sum_ay  = AVG_W'(fmy_q) + AVG_W'(mean_s3);
	assign ax      = sum_ax[AVG_W-1:1];
	assign ay      = sum_ay[AVG_W-1:1];

	// stage 4
	kind_t               kind_s4;
	logic                agreed_s4;
	logic [ADC_BITS-1:0] ax_s4, ay_s4;

	always_ff @(posedge clk) begin
		kind_s4   <= kind_s3;
		agreed_s4 <= (kind_s3 == KIND_GROUP) && agree_x && agree_y;
		ax_s4     <= ax;
		ay_s4     <= ay;
	end

	// stage 5: gain products
	kind_t                    kind_s5;
	logic                     agreed_s5;
	logic [ADC_BITS-1:0]      ax_s5, ay_s5;
	logic signed [MUL_W-1:0]  mul_x_s5, mul_y_s5;

	always_ff @(posedge clk) begin
		kind_s5   <= kind_s4;
		agreed_s5 <= agreed_s4;
		ax_s5     <= ax_s4;
		ay_s5     <= ay_s4;
		mul_x_s5  <= $signed({1'b0, ax_s4}) * x_gain_q;
		mul_y_s5  <= $signed({1'b0, ay_s4}) * y_gain_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_fire && ((cmd == CMD_PEN_UP) || (cmd == CMD_CLEAR) || grp_end);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && ((kind_s3 != KIND_GROUP) || (gidx_s3 == GRP_Y1));
			v_s5 <= v_s4;
		end
	end

	// offset, floor shift and saturation
	function automatic logic [POS_W-1:0] cal_sat(input logic signed [MUL_W-1:0] p,
			input logic signed [GAIN_W-1:0] off);
		logic signed [T_W-1:0] t;
		logic [Q_W-1:0]        q;
		t = T_W'(p) + (T_W'(off) <<< CAL_SHIFT);
		q = t[T_W-1:CAL_SHIFT];
		if (t[T_W-1])
			cal_sat = '0;
		else if (|q[Q_W-1:POS_W])
			cal_sat = NO_TOUCH;
		else
			cal_sat = q[POS_W-1:0];
	endfunction

	logic [POS_W-1:0] cal_x, cal_y;

	assign cal_x = raw_mode_q ? POS_W'(ax_s5) : cal_sat(mul_x_s5, x_off_q);
	assign cal_y = raw_mode_q ? POS_W'(ay_s5) : cal_sat(mul_y_s5, y_off_q);

	// pen and position state
	logic [POS_W-1:0] cur_x_q, cur_y_q, start_x_q, start_y_q;
	logic             pen_q, caught_q;
	logic [POS_W-1:0] nx_cur_x, nx_cur_y, nx_start_x, nx_start_y;
	logic             nx_pen, nx_caught, nx_agreed;
	result_t          res;

	always_comb begin
		nx_cur_x   = cur_x_q;
		nx_cur_y   = cur_y_q;
		nx_start_x = start_x_q;
		nx_start_y = start_y_q;
		nx_pen     = pen_q;
		nx_caught  = caught_q;
		nx_agreed  = 1'b0;
		case (kind_s5)
			KIND_PEN_UP: begin
				if (pen_q) begin
					nx_pen = 1'b0;
				end else begin
					nx_start_x = '0;
					nx_start_y = '0;
					nx_cur_x   = NO_TOUCH;
					nx_cur_y   = NO_TOUCH;
				end
			end
			KIND_CLEAR: begin
				nx_caught = 1'b0;
			end
			KIND_GROUP: begin
				if (agreed_s5) begin
					nx_cur_x  = cal_x;
					nx_cur_y  = cal_y;
					nx_agreed = 1'b1;
				end
				if (!pen_q) begin
					nx_pen     = 1'b1;
					nx_caught  = 1'b1;
					nx_start_x = nx_cur_x;
					nx_start_y = nx_cur_y;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
			pen_q     <= 1'b0;
			caught_q  <= 1'b0;
		end else if (v_s5) begin
			cur_x_q   <= nx_cur_x;
			cur_y_q   <= nx_cur_y;
			start_x_q <= nx_start_x;
			start_y_q <= nx_start_y;
			pen_q     <= nx_pen;
			caught_q  <= nx_caught;
		end
	end

	always_comb begin
		res.pos_x       = nx_cur_x;
		res.pos_y       = nx_cur_y;
		res.press_x     = nx_start_x;
		res.press_y     = nx_start_y;
		res.pressed     = nx_pen;
		res.caught      = nx_caught;
		res.pair_agreed = nx_agreed;
	end

	// output fifo
	result_t               fifo_mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] fifo_cnt_q;
	logic                  rd_fire;
	logic [2:0]            busy_cnt;

	assign rd_fire       = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = (fifo_cnt_q != '0);
	assign m_axis_tdata  = OUT_DATA_W'(fifo_mem_q[rd_ptr_q]);
	assign busy_cnt      = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4) + 3'(v_s5);
	assign s_axis_tready = ((FIFO_CNT_W + 1)'(fifo_cnt_q) + (FIFO_CNT_W + 1)'(busy_cnt))
		< (FIFO_CNT_W + 1)'(FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (v_s5)
			fifo_mem_q[wr_ptr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (v_s5)
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			if (rd_fire)
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			fifo_cnt_q <= fifo_cnt_q + FIFO_CNT_W'(v_s5) - FIFO_CNT_W'(rd_fire);
		end
	end

endmodule
